// ===== design/dtt_pkg.sv =====
// Shared types and constants for the detection track table.
package dtt_pkg;

  // Request codes
  localparam logic [1:0] REQ_FRAME_START = 2'd0;
  localparam logic [1:0] REQ_DETECT      = 2'd1;
  localparam logic [1:0] REQ_FRAME_END   = 2'd2;
  localparam logic [1:0] REQ_UNUSED      = 2'd3;

  // Result action codes
  localparam logic [2:0] ACT_DONE    = 3'd0;
  localparam logic [2:0] ACT_GATED   = 3'd1;
  localparam logic [2:0] ACT_ADDED   = 3'd2;
  localparam logic [2:0] ACT_UPDATED = 3'd3;
  localparam logic [2:0] ACT_REMOVED = 3'd4;
  localparam logic [2:0] ACT_FULL    = 3'd5;
  localparam logic [2:0] ACT_IGNORED = 3'd6;
  localparam logic [2:0] ACT_PURGED  = 3'd7;

  // Configuration register indexes
  localparam logic [2:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_BORDER_PAD   = 3'd2;
  localparam logic [2:0] CFG_NEAR_WINDOW  = 3'd3;
  localparam logic [2:0] CFG_INITIAL_LIFE = 3'd4;

  localparam int AREA_BITS = 25;
  localparam logic [AREA_BITS-1:0] AREA_MAX = {AREA_BITS{1'b1}};
  localparam logic [AREA_BITS-1:0] LOWER_RESET = 25'd200;
  localparam logic [14:0] START_DIST = 15'd10000;

endpackage

// ===== design/dtt_ram.sv =====
// Generic RAM with one write port and one registered read port.
module dtt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/detection_track_table.sv =====
// Top level of the detection track table: sequencer, shared multiplier and table RAM.
//
// Usage: raise start with req_type_i and the box fields while busy is low.
// The block raises busy for the length of the item and then shows exactly one
// result (action_o, slot_o, target_total_o) for one cycle with done_o high.
// Configuration is written through cfg_we_i / cfg_index_i / cfg_wdata_i while
// idle; a write takes effect at once.
// Work per item, with N entries in the table (all work goes through the one table
// RAM, whose read port reads one entry a cycle, and one shared 25x25 multiplier):
//   frame start: area products, then a life sweep over the N entries
//   detection:   the gates and the nearest search over the N entries,
//                plus a shift of the later entries when an entry is removed
//   frame end:   a scan that purges zero-life entries, each with a shift
// Only one item is in flight; busy drops in the done_o cycle, so the next item
// can be accepted at the edge that ends the result cycle.
// Reset empties the table (count to zero), restores the area bounds and the
// registers; no clearing pass is needed. The receiver cannot stall.
module detection_track_table #(
  parameter int MAX_TARGETS = 20,
  parameter int COORD_BITS  = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            req_type_i,
  input  logic [11:0]           box_x_i,
  input  logic [11:0]           box_y_i,
  input  logic [11:0]           box_w_i,
  input  logic [11:0]           box_h_i,
  input  logic [23:0]           region_area_i,
  input  logic                  classifier_hit_i,
  input  logic                  current_frame_only_i,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_index_i,
  input  logic [11:0]           cfg_wdata_i,
  output logic                  done_o,
  output logic [2:0]            action_o,
  output logic [4:0]            slot_o,
  output logic [4:0]            target_total_o
);
  import dtt_pkg::*;

  localparam int IW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int CW = $clog2(MAX_TARGETS + 1);
  localparam int EW = 4 * COORD_BITS + 8;

  // Sequencer states
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_FS_RD0  = 5'd1;
  localparam logic [4:0] S_FS_M0   = 5'd2;
  localparam logic [4:0] S_FS_M1   = 5'd3;
  localparam logic [4:0] S_FS_RDL  = 5'd4;
  localparam logic [4:0] S_FS_M2   = 5'd5;
  localparam logic [4:0] S_FS_LRD  = 5'd6;
  localparam logic [4:0] S_FS_LWR  = 5'd7;
  localparam logic [4:0] S_DT_G0   = 5'd8;
  localparam logic [4:0] S_DT_G1   = 5'd9;
  localparam logic [4:0] S_DT_G2   = 5'd10;
  localparam logic [4:0] S_DT_G3   = 5'd11;
  localparam logic [4:0] S_DT_G4   = 5'd12;
  localparam logic [4:0] S_DT_SRD  = 5'd13;
  localparam logic [4:0] S_DT_SCMP = 5'd14;
  localparam logic [4:0] S_DT_DEC  = 5'd15;
  localparam logic [4:0] S_DT_UPR  = 5'd16;
  localparam logic [4:0] S_DT_UPW  = 5'd17;
  localparam logic [4:0] S_SH_RD   = 5'd18;
  localparam logic [4:0] S_SH_WR   = 5'd19;
  localparam logic [4:0] S_FE_RD   = 5'd20;
  localparam logic [4:0] S_FE_CHK  = 5'd21;
  localparam logic [4:0] S_DONE    = 5'd22;

  // Configuration registers
  logic [11:0] frame_width_q, frame_height_q, near_window_q;
  logic [7:0]  border_pad_q, initial_life_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= 12'd640;
      frame_height_q <= 12'd480;
      border_pad_q   <= 8'd10;
      near_window_q  <= 12'd50;
      initial_life_q <= 8'd5;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i;
        CFG_BORDER_PAD:   border_pad_q   <= cfg_wdata_i[7:0];
        CFG_NEAR_WINDOW:  near_window_q  <= cfg_wdata_i;
        CFG_INITIAL_LIFE: initial_life_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Table RAM: one entry {x, y, w, h, life} per word
  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  dtt_ram #(.Width(EW), .Depth(MAX_TARGETS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic [COORD_BITS-1:0] rd_x, rd_y, rd_w, rd_h;
  logic [7:0]            rd_life;
  assign {rd_x, rd_y, rd_w, rd_h, rd_life} = ram_rdata;

  // Shared multiplier, registered product
  logic [24:0] mul_a, mul_b;
  logic [49:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Item and working registers
  logic [4:0]            state_q, state_d;
  logic [1:0]            req_q;
  logic [11:0]           bx_q, by_q, bw_q, bh_q;
  logic [23:0]           area_q;
  logic                  hit_q, cur_q;
  logic [CW-1:0]         count_q, count_d;
  logic [AREA_BITS-1:0]  upper_q, upper_d, lower_q, lower_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [IW-1:0]         best_idx_q, best_idx_d;
  logic [14:0]           best_q, best_d;
  logic                  near_q, near_d;
  logic                  gate_q, gate_d;
  logic [49:0]           tmp_q, tmp_d;
  logic [2:0]            act_q, act_d;
  logic [4:0]            slot_q, slot_d;
  logic                  done_q, done_d;

  // Border test in signed 16-bit arithmetic
  logic signed [15:0] sx, sy, sw, sh, spad, swid, shgt;
  logic               ok_border;
  assign sx   = signed'({4'd0, bx_q});
  assign sy   = signed'({4'd0, by_q});
  assign sw   = signed'({4'd0, bw_q});
  assign sh   = signed'({4'd0, bh_q});
  assign spad = signed'({8'd0, border_pad_q});
  assign swid = signed'({4'd0, frame_width_q});
  assign shgt = signed'({4'd0, frame_height_q});
  assign ok_border = (sx > spad) && (sy > spad) && (sx + sw < swid - spad) &&
                     (sy + sh < shgt - spad);

  // Distance to the entry read this cycle
  logic [12:0] ex13, ey13, bx13, by13;
  logic [12:0] dx, dy;
  logic [13:0] dsum;
  assign ex13 = 13'(rd_x);
  assign ey13 = 13'(rd_y);
  assign bx13 = {1'b0, bx_q};
  assign by13 = {1'b0, by_q};
  assign dx   = (bx13 >= ex13) ? bx13 - ex13 : ex13 - bx13;
  assign dy   = (by13 >= ey13) ? by13 - ey13 : ey13 - by13;
  assign dsum = {1'b0, dx} + {1'b0, dy};

  logic [EW-1:0] new_entry;
  assign new_entry = {COORD_BITS'(bx_q), COORD_BITS'(by_q), COORD_BITS'(bw_q),
                      COORD_BITS'(bh_q), 8'd0};

  logic [49:0] area2;
  assign area2 = {25'd0, area_q, 1'b0};

  assign busy = (state_q != S_IDLE);

  // Sequencer
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    upper_d    = upper_q;
    lower_d    = lower_q;
    idx_d      = idx_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    near_d     = near_q;
    gate_d     = gate_q;
    tmp_d      = tmp_q;
    act_d      = act_q;
    slot_d     = slot_q;
    done_d     = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = idx_q[IW-1:0];
    ram_wdata  = ram_rdata;
    ram_raddr  = idx_q[IW-1:0];
    mul_a      = '0;
    mul_b      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          act_d  = ACT_DONE;
          slot_d = '0;
          idx_d  = '0;
          unique case (req_type_i)
            REQ_FRAME_START: state_d = S_FS_RD0;
            REQ_DETECT:      state_d = S_DT_G0;
            REQ_FRAME_END:   state_d = S_FE_RD;
            default:         state_d = S_DONE;
          endcase
        end
      end

      // Frame start: W*H, then entry products, then life sweep
      S_FS_RD0: begin
        ram_raddr = '0;
        mul_a = 25'(frame_width_q);
        mul_b = 25'(frame_height_q);
        state_d = S_FS_M0;
      end
      S_FS_M0: begin
        tmp_d = {prod_q[49:1], 1'b0};
        mul_a = 25'(rd_w);
        mul_b = 25'(rd_h);
        ram_raddr = IW'(count_q - CW'(1));
        state_d = S_FS_M1;
      end
      S_FS_M1: begin
        // prod_q holds w0*h0; keep the last entry on the read port
        ram_raddr = IW'(count_q - CW'(1));
        if (count_q != '0 && {prod_q[47:0], 2'b00} < tmp_q && prod_q[49:48] == 2'b00) begin
          tmp_d = {prod_q[47:0], 2'b00};
        end
        state_d = S_FS_RDL;
      end
      S_FS_RDL: begin
        upper_d = (tmp_q > 50'(AREA_MAX)) ? AREA_MAX : tmp_q[AREA_BITS-1:0];
        mul_a = 25'(rd_w);
        mul_b = 25'(rd_h);
        state_d = S_FS_M2;
      end
      S_FS_M2: begin
        if (count_q != '0 && prod_q > 50'(LOWER_RESET)) begin
          lower_d = (prod_q > 50'(AREA_MAX)) ? AREA_MAX : prod_q[AREA_BITS-1:0];
        end else begin
          lower_d = LOWER_RESET;
        end
        idx_d = '0;
        state_d = S_FS_LRD;
      end
      S_FS_LRD: begin
        if (idx_q >= count_q) begin
          state_d = S_DONE;
        end else begin
          state_d = S_FS_LWR;
        end
      end
      S_FS_LWR: begin
        ram_we    = 1'b1;
        ram_wdata = {ram_rdata[EW-1:8], rd_life - 8'd1};
        idx_d     = idx_q + CW'(1);
        ram_raddr = IW'(idx_q + CW'(1));
        state_d   = S_FS_LRD;
      end

      // Detection gates: hit flag and area, then aspect through the shared multiplier
      S_DT_G0: begin
        gate_d = !hit_q || (area2 > 50'(upper_q)) || (area2 < 50'(lower_q));
        mul_a = 25'd5;
        mul_b = 25'(bw_q);
        state_d = S_DT_G1;
      end
      S_DT_G1: begin
        tmp_d = prod_q;
        mul_a = 25'd3;
        mul_b = 25'(bh_q);
        state_d = S_DT_G2;
      end
      S_DT_G2: begin
        if (tmp_q < prod_q) gate_d = 1'b1;
        mul_a = 25'd10;
        mul_b = 25'(bw_q);
        state_d = S_DT_G3;
      end
      S_DT_G3: begin
        tmp_d = prod_q;
        mul_a = 25'd13;
        mul_b = 25'(bh_q);
        state_d = S_DT_G4;
      end
      S_DT_G4: begin
        if (gate_d || tmp_q > prod_q || gate_q) begin
          act_d   = ACT_GATED;
          state_d = S_DONE;
        end else begin
          idx_d      = '0;
          best_d     = START_DIST;
          best_idx_d = '0;
          near_d     = 1'b0;
          state_d    = S_DT_SRD;
        end
      end
      S_DT_SRD: begin
        if (idx_q >= count_q) begin
          state_d = S_DT_DEC;
        end else begin
          state_d = S_DT_SCMP;
        end
      end
      S_DT_SCMP: begin
        if (dx <= 13'(near_window_q) && dy <= 13'(near_window_q)) begin
          near_d = 1'b1;
          if ({1'b0, dsum} < best_q) begin
            best_d     = {1'b0, dsum};
            best_idx_d = idx_q[IW-1:0];
          end
        end
        idx_d     = idx_q + CW'(1);
        ram_raddr = IW'(idx_q + CW'(1));
        state_d   = S_DT_SRD;
      end
      S_DT_DEC: begin
        ram_raddr = best_idx_q;
        if (!near_q) begin
          if (cur_q || !ok_border) begin
            act_d   = ACT_IGNORED;
            state_d = S_DONE;
          end else if (count_q >= CW'(MAX_TARGETS)) begin
            act_d   = ACT_FULL;
            state_d = S_DONE;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = count_q[IW-1:0];
            ram_wdata = {new_entry[EW-1:8], initial_life_q};
            slot_d    = 5'(count_q);
            count_d   = count_q + CW'(1);
            act_d     = ACT_ADDED;
            state_d   = S_DONE;
          end
        end else if (ok_border) begin
          slot_d  = 5'(best_idx_q);
          act_d   = ACT_UPDATED;
          state_d = S_DT_UPR;
        end else begin
          slot_d  = 5'(best_idx_q);
          act_d   = ACT_REMOVED;
          idx_d   = CW'(best_idx_q);
          ram_raddr = IW'(CW'(best_idx_q) + CW'(1));
          state_d = S_SH_RD;
        end
      end
      S_DT_UPR: begin
        // Hold the matched entry on the read port
        ram_raddr = best_idx_q;
        state_d = S_DT_UPW;
      end
      S_DT_UPW: begin
        ram_we    = 1'b1;
        ram_waddr = best_idx_q;
        ram_wdata = {new_entry[EW-1:8], rd_life + 8'd1};
        state_d   = S_DONE;
      end

      // Shift later entries down one slot from idx_q
      S_SH_RD: begin
        ram_raddr = IW'(idx_q + CW'(1));
        if (idx_q + CW'(1) >= count_q) begin
          count_d = count_q - CW'(1);
          if (req_q == REQ_FRAME_END) begin
            // Resume the purge at the slot that was just refilled
            idx_d     = CW'(best_idx_q);
            ram_raddr = best_idx_q;
            state_d   = S_FE_RD;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          state_d = S_SH_WR;
        end
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[IW-1:0];
        idx_d     = idx_q + CW'(1);
        ram_raddr = IW'(idx_q + CW'(2));
        state_d   = S_SH_RD;
      end

      // Frame end: purge zero-life entries
      S_FE_RD: begin
        if (idx_q >= count_q) begin
          state_d = S_DONE;
        end else begin
          state_d = S_FE_CHK;
        end
      end
      S_FE_CHK: begin
        if (rd_life == 8'd0) begin
          act_d      = ACT_PURGED;
          best_idx_d = idx_q[IW-1:0];
          ram_raddr  = IW'(idx_q + CW'(1));
          state_d    = S_SH_RD;
        end else begin
          idx_d     = idx_q + CW'(1);
          ram_raddr = IW'(idx_q + CW'(1));
          state_d   = S_FE_RD;
        end
      end

      S_DONE: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      upper_q <= '0;
      lower_q <= LOWER_RESET;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      upper_q <= upper_d;
      lower_q <= lower_d;
      done_q  <= done_d;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q  <= req_type_i;
      bx_q   <= box_x_i;
      by_q   <= box_y_i;
      bw_q   <= box_w_i;
      bh_q   <= box_h_i;
      area_q <= region_area_i;
      hit_q  <= classifier_hit_i;
      cur_q  <= current_frame_only_i;
    end
    idx_q      <= idx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    near_q     <= near_d;
    gate_q     <= gate_d;
    tmp_q      <= tmp_d;
    act_q      <= act_d;
    slot_q     <= slot_d;
  end

  // Result beat
  assign done_o         = done_q;
  assign action_o       = act_q;
  assign slot_o         = slot_q;
  assign target_total_o = 5'(count_q);

endmodule

// ===== tb/dtt_checker.sv =====
// Scoreboard for the detection track table: mirrors the table and checks every result beat.
module dtt_checker #(
  parameter int MAX_TARGETS = 20,
  parameter int COORD_BITS  = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [11:0] box_x_i,
  input  logic [11:0] box_y_i,
  input  logic [11:0] box_w_i,
  input  logic [11:0] box_h_i,
  input  logic [23:0] region_area_i,
  input  logic        classifier_hit_i,
  input  logic        current_frame_only_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        done_o,
  input  logic [2:0]  action_o,
  input  logic [4:0]  slot_o,
  input  logic [4:0]  target_total_o,
  output int          fail_count_o,
  output int          pending_o
);
  import dtt_pkg::*;

  typedef struct packed {
    logic [2:0] action;
    logic [4:0] slot;
    logic [4:0] total;
  } verdict_t;

  localparam logic [COORD_BITS-1:0] COORD_MASK = '1;

  logic [11:0] width_q, height_q, near_q;
  logic [7:0]  pad_q, life_init_q;
  logic [COORD_BITS-1:0] tx [MAX_TARGETS];
  logic [COORD_BITS-1:0] ty [MAX_TARGETS];
  logic [COORD_BITS-1:0] tw [MAX_TARGETS];
  logic [COORD_BITS-1:0] th [MAX_TARGETS];
  logic [7:0]  tlife [MAX_TARGETS];
  int          tcount;
  longint      upper_q, lower_q;
  verdict_t    verdict_q[$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = verdict_q.size();

  // Close the gap left by entry k
  task automatic drop_target(input int k);
    for (int i = k; i + 1 < tcount; i++) begin
      tx[i] = tx[i+1]; ty[i] = ty[i+1]; tw[i] = tw[i+1]; th[i] = th[i+1];
      tlife[i] = tlife[i+1];
    end
    tcount--;
  endtask

  // Work out the result of one request and advance the table
  task automatic track_request();
    verdict_t v;
    longint up, lo, a2, bx, by, bw, bh, dx, dy, pad;
    longint best;
    int idx, i;
    bit fresh, ok;
    v = '0;
    bx = box_x_i; by = box_y_i; bw = box_w_i; bh = box_h_i;
    pad = pad_q;
    case (req_type_i)
      REQ_FRAME_START: begin
        up = ((longint'(width_q) * height_q) / 2) * 2;
        lo = 200;
        if (tcount > 0) begin
          if (4 * longint'(tw[0]) * th[0] < up) up = 4 * longint'(tw[0]) * th[0];
          if (longint'(tw[tcount-1]) * th[tcount-1] > lo)
            lo = longint'(tw[tcount-1]) * th[tcount-1];
        end
        upper_q = (up > AREA_MAX) ? longint'(AREA_MAX) : up;
        lower_q = (lo > AREA_MAX) ? longint'(AREA_MAX) : lo;
        for (i = 0; i < tcount; i++) tlife[i] = tlife[i] - 8'd1;
        v.action = ACT_DONE;
      end
      REQ_DETECT: begin
        a2 = 2 * longint'(region_area_i);
        if (a2 > upper_q || a2 < lower_q || 5 * bw < 3 * bh || 10 * bw > 13 * bh ||
            !classifier_hit_i) begin
          v.action = ACT_GATED;
        end else begin
          fresh = 1; best = START_DIST; idx = 0;
          ok = bx > pad && by > pad && bx + bw < longint'(width_q) - pad &&
               by + bh < longint'(height_q) - pad;
          // Nearest entry within the per-axis window
          for (i = 0; i < tcount; i++) begin
            dx = bx - tx[i]; dy = by - ty[i];
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            if (dx > near_q || dy > near_q) continue;
            if (dx + dy < best) begin
              best = dx + dy; idx = i;
            end
            fresh = 0;
          end
          if (fresh) begin
            if (current_frame_only_i || !ok) v.action = ACT_IGNORED;
            else if (tcount >= MAX_TARGETS) v.action = ACT_FULL;
            else begin
              tx[tcount] = box_x_i & COORD_MASK; ty[tcount] = box_y_i & COORD_MASK;
              tw[tcount] = box_w_i & COORD_MASK; th[tcount] = box_h_i & COORD_MASK;
              tlife[tcount] = life_init_q;
              v.slot = 5'(tcount);
              tcount++;
              v.action = ACT_ADDED;
            end
          end else if (ok) begin
            tx[idx] = box_x_i & COORD_MASK; ty[idx] = box_y_i & COORD_MASK;
            tw[idx] = box_w_i & COORD_MASK; th[idx] = box_h_i & COORD_MASK;
            tlife[idx] = tlife[idx] + 8'd1;
            v.slot = 5'(idx);
            v.action = ACT_UPDATED;
          end else begin
            drop_target(idx);
            v.slot = 5'(idx);
            v.action = ACT_REMOVED;
          end
        end
      end
      REQ_FRAME_END: begin
        v.action = ACT_DONE;
        i = 0;
        while (i < tcount) begin
          if (tlife[i] == 8'd0) begin
            drop_target(i);
            v.action = ACT_PURGED;
          end else i++;
        end
      end
      default: v.action = ACT_DONE;
    endcase
    v.total = 5'(tcount);
    verdict_q = {verdict_q, v};
  endtask

  // Follow register writes, requests and result beats
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t exp_v;
    if (!rst_ni) begin
      width_q = 12'd640; height_q = 12'd480; pad_q = 8'd10;
      near_q = 12'd50; life_init_q = 8'd5;
      tcount = 0; upper_q = 0; lower_q = LOWER_RESET;
      verdict_q.delete();
      fails = 0;
    end else begin
      if (done_o) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: action %0d slot %0d total %0d",
                   $time, action_o, slot_o, target_total_o);
          fails++;
        end else begin
          exp_v = verdict_q.pop_front();
          if (action_o !== exp_v.action) begin
            $display("%0t: action expected %0d actual %0d", $time, exp_v.action, action_o);
            fails++;
          end
          if (slot_o !== exp_v.slot) begin
            $display("%0t: slot expected %0d actual %0d", $time, exp_v.slot, slot_o);
            fails++;
          end
          if (target_total_o !== exp_v.total) begin
            $display("%0t: target_total expected %0d actual %0d", $time, exp_v.total,
                     target_total_o);
            fails++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_FRAME_WIDTH:  width_q = cfg_wdata_i;
          CFG_FRAME_HEIGHT: height_q = cfg_wdata_i;
          CFG_BORDER_PAD:   pad_q = cfg_wdata_i[7:0];
          CFG_NEAR_WINDOW:  near_q = cfg_wdata_i;
          CFG_INITIAL_LIFE: life_init_q = cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (start && !busy) track_request();
    end
  end

endmodule

// ===== tb/tb_detection_track_table.sv =====
// Stimulus, clock, reset and verdict for the detection track table.
module tb_detection_track_table;
  import dtt_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type_i = REQ_FRAME_START;
  logic [11:0] box_x_i = '0, box_y_i = '0, box_w_i = 12'd1, box_h_i = 12'd1;
  logic [23:0] region_area_i = '0;
  logic        classifier_hit_i = 1'b0, current_frame_only_i = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = CFG_FRAME_WIDTH;
  logic [11:0] cfg_wdata_i = '0;
  logic        done_o;
  logic [2:0]  action_o;
  logic [4:0]  slot_o, target_total_o;
  int          fail_count, pending;
  int          idle_pct;
  int          stall_cycles;
  int          hist_x[8], hist_y[8];
  int          hist_n;

  always #10 clk_i = ~clk_i;

  detection_track_table dut (.*);

  dtt_checker scoreboard (
    .clk_i, .rst_ni, .start, .busy, .req_type_i, .box_x_i, .box_y_i, .box_w_i, .box_h_i,
    .region_area_i, .classifier_hit_i, .current_frame_only_i, .cfg_we_i, .cfg_index_i,
    .cfg_wdata_i, .done_o, .action_o, .slot_o, .target_total_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) stall_cycles <= 0;
    else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else stall_cycles <= stall_cycles + 1;
  end

  // Present one request and hold it until the block takes the beat; may idle afterwards
  task automatic send_request(input logic [1:0] req, input int x, input int y, input int w,
                              input int h, input int area, input bit hit, input bit cur);
    req_type_i <= req; box_x_i <= 12'(x); box_y_i <= 12'(y);
    box_w_i <= 12'(w); box_h_i <= 12'(h);
    region_area_i <= 24'(area); classifier_hit_i <= hit; current_frame_only_i <= cur;
    start <= 1'b1;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Wait until no request is in flight and every result beat has been checked
  task automatic drain();
    start <= 1'b0;
    @(negedge clk_i);
    while (busy || pending != 0) @(negedge clk_i);
  endtask

  // Detection with a plausible shape and a region area drawn from 1550 to 2480
  task automatic send_detection(input int x, input int y, input bit cur);
    int w, h;
    w = $urandom_range(40, 50);
    h = $urandom_range((10 * w + 12) / 13, (5 * w) / 3);
    send_request(REQ_DETECT, x, y, w, h, $urandom_range(1550, 2480),
                 $urandom_range(0, 9) != 0, cur);
    hist_x[hist_n % 8] = x;
    hist_y[hist_n % 8] = y;
    hist_n++;
  endtask

  // Let the block drain, then load all five registers
  task automatic load_settings(input int w, input int h, input int pad, input int win,
                               input int life);
    int vals[5];
    drain();
    repeat (10) @(posedge clk_i);
    vals = '{w, h, pad, win, life};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i <= 1'b1; cfg_index_i <= 3'(i); cfg_wdata_i <= 12'(vals[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    int pick, k;
    idle_pct = 37;
    hist_n = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: gates, add, ignore, update, remove, frame ends, unused request
    send_request(REQ_FRAME_START, 0, 0, 1, 1, 0, 0, 0);
    send_request(REQ_DETECT, 100, 100, 40, 40, 0, 1, 0);
    send_request(REQ_DETECT, 100, 100, 40, 40, 16777215, 1, 0);
    send_request(REQ_DETECT, 100, 100, 20, 40, 1000, 1, 0);
    send_request(REQ_DETECT, 100, 100, 40, 20, 1000, 1, 0);
    send_request(REQ_DETECT, 100, 100, 40, 40, 1000, 0, 0);
    send_request(REQ_DETECT, 100, 100, 40, 40, 1000, 1, 0);
    send_request(REQ_DETECT, 300, 300, 40, 40, 1000, 1, 1);
    send_request(REQ_DETECT, 5, 300, 40, 40, 1000, 1, 0);
    send_request(REQ_DETECT, 30, 300, 40, 40, 1000, 1, 0);
    send_request(REQ_DETECT, 110, 95, 41, 40, 1000, 1, 0);
    send_request(REQ_DETECT, 8, 300, 40, 40, 1000, 1, 0);
    send_request(REQ_DETECT, 4095, 4095, 4095, 4095, 1000, 1, 0);
    send_request(REQ_FRAME_END, 0, 0, 1, 1, 0, 0, 0);
    for (k = 0; k < 7; k++) send_request(REQ_FRAME_START, 0, 0, 1, 1, 0, 0, 0);
    send_request(REQ_FRAME_END, 0, 0, 1, 1, 0, 0, 0);
    send_request(REQ_UNUSED, 4095, 4095, 4095, 4095, 16777215, 1, 1);

    // Random phases over several register settings and idle rates
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin idle_pct = 37; load_settings(640, 480, 10, 50, 5); end
        1: begin idle_pct = 71; load_settings(4095, 4095, 0, 4095, 255); end
        2: begin idle_pct = 0; load_settings(1, 1, 255, 0, 1); end
        3: begin idle_pct = 0; load_settings(800, 600, 20, 30, 2); end
        default: begin idle_pct = 0; load_settings(640, 480, 10, 50, 5); end
      endcase
      if (phase == 2) k = 40; else k = 240;
      while (k > 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          // noise over the full field ranges
          send_request(2'($urandom_range(0, 3)), $urandom_range(0, 4095),
                       $urandom_range(0, 4095),
                       $urandom_range(1, 4095), $urandom_range(1, 4095),
                       $urandom_range(0, 16777215), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
          k--;
        end else if (pick < 16) begin
          // fill the table on a grid to reach the full case
          send_request(REQ_FRAME_START, 0, 0, 1, 1, 0, 0, 0);
          for (int g = 0; g < 24; g++)
            send_detection(40 + (g % 5) * 110, 40 + (g / 5) * 80, 0);
          send_request(REQ_FRAME_END, 0, 0, 1, 1, 0, 0, 0);
          k -= 26;
        end else begin
          // one frame: start, a few detections near known targets or new, end
          send_request(REQ_FRAME_START, 0, 0, 1, 1, 0, 0, 0);
          repeat ($urandom_range(1, 5)) begin
            if (hist_n > 0 && $urandom_range(0, 2) != 0)
              send_detection(hist_x[$urandom_range(0, (hist_n < 8 ? hist_n : 8) - 1)] +
                             $urandom_range(0, 60) - 30,
                             hist_y[$urandom_range(0, (hist_n < 8 ? hist_n : 8) - 1)] +
                             $urandom_range(0, 60) - 30, $urandom_range(0, 3) == 0);
            else
              send_detection($urandom_range(0, 620), $urandom_range(0, 460),
                             $urandom_range(0, 3) == 0);
            k--;
          end
          send_request(REQ_FRAME_END, 0, 0, 1, 1, 0, 0, 0);
          k -= 2;
        end
      end
    end

    // Drain and give the verdict
    drain();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
